/* sv/rc_pkg.sv */
// Shared types, constants and a helper function of the relation closure block.
`default_nettype none

package rc_pkg;

    // Fixed widths of the payload and configuration fields.
    localparam int ROW_W      = 32;
    localparam int IDX_W      = 5;
    localparam int SIZE_W     = 6;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Default row store limit.
    localparam int MAX_SIZE_DEFAULT = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSURE_MODE = 1'd1;

    // Closure modes; any other code leaves the matrix unchanged.
    localparam logic [MODE_W-1:0] MODE_REFLEXIVE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYMMETRIC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRANSITIVE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET  = 6'd32;
    localparam logic [MODE_W-1:0] CLOSURE_MODE_RESET = MODE_TRANSITIVE;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_CAP,
        ST_TROW_RD,
        ST_TROW_UPD,
        ST_SCOL_RD,
        ST_SCOL_ACC,
        ST_SROW_RD,
        ST_SROW_UPD,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    // Request to the shared conditional-OR row unit.
    typedef struct packed {
        logic [ROW_W-1:0] base;
        logic [ROW_W-1:0] operand;
        logic [ROW_W-1:0] test_word;
        logic [IDX_W-1:0] test_sel;
        logic             force_test;
    } unit_req_t;

    // Mask with the low n column bits set.
    function automatic logic [ROW_W-1:0] col_mask(input logic [SIZE_W-1:0] n);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            m[b] = (SIZE_W'(b) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/rc_row_unit.sv */
// Shared row unit: ORs an operand row into a base row when a selected test bit is set.
`default_nettype none

module rc_row_unit (
    input  wire rc_pkg::unit_req_t        req,
    output logic [rc_pkg::ROW_W-1:0]      result
);

    logic test;

    // Condition comes from one bit of the test word or is forced.
    always_comb
    begin
        test   = req.force_test | req.test_word[req.test_sel];
        result = req.base | ({rc_pkg::ROW_W{test}} & req.operand);
    end

endmodule

`default_nettype wire

/* sv/relation_closure_core.sv */
// Top level of the relation closure block: row store, sequencer and output register.
//
// The block loads an N x N 0/1 relation one row per transaction (one row per cycle
// while not stalled), where N is matrix_size limited to 1..min(MAX_SIZE, 32). The row
// that completes the matrix starts the closure chosen by closure_mode, done by a small
// sequencer around one shared conditional-OR row unit and a single-port row store with
// a registered read. Every row access is a read, then a use or a write back, and the
// transitive closure follows Warshall pivoting. Emission reads each row and hands it
// to the output register, with the last row marked. Input is stalled from the
// completing row until the last row is handed to the output register; the output
// register lets that last row wait while the next matrix starts loading.
`default_nettype none

module relation_closure_core #(
    parameter int MAX_SIZE = rc_pkg::MAX_SIZE_DEFAULT
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // Configuration write port
    input  wire                               cfg_we,
    input  wire  [rc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [rc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire  [rc_pkg::ROW_W-1:0]          row_bits,
    // Output channel
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [rc_pkg::ROW_W-1:0]          closed_row,
    output logic [rc_pkg::IDX_W-1:0]          row_index,
    output logic                              last_row
);

    localparam int DEPTH  = (MAX_SIZE < rc_pkg::ROW_W) ? MAX_SIZE : rc_pkg::ROW_W;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int ROW_W  = rc_pkg::ROW_W;
    localparam int SIZE_W = rc_pkg::SIZE_W;

    // Configuration registers.
    logic [SIZE_W-1:0]         matrix_size_reg;
    logic [rc_pkg::MODE_W-1:0] closure_mode_reg;

    // Sequencer and datapath state.
    rc_pkg::state_t            state_reg, state_next;
    logic [SIZE_W-1:0]         rows_loaded_reg, rows_loaded_next;
    logic [ADDR_W-1:0]         k_reg, k_next;
    logic [ADDR_W-1:0]         j_reg, j_next;
    logic [ADDR_W-1:0]         nlast_reg, nlast_next;
    logic [ROW_W-1:0]          mask_reg, mask_next;
    logic [rc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [ROW_W-1:0]          pivot_reg, pivot_next;
    logic [ROW_W-1:0]          acc_reg, acc_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]          closed_row_reg, closed_row_next;
    logic [rc_pkg::IDX_W-1:0]  row_index_reg, row_index_next;
    logic                      last_row_reg, last_row_next;

    // Row store.
    logic [ROW_W-1:0]          row_mem [DEPTH];
    logic [ROW_W-1:0]          rd_data_reg;
    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_wa, mem_ra;
    logic [ROW_W-1:0]          mem_wd;

    // Combinational helpers.
    logic [SIZE_W-1:0]         n_cur;
    logic [ROW_W-1:0]          mask_cur;
    logic                      in_accept;
    logic                      complete;
    logic [SIZE_W:0]           rl_inc;
    logic [ROW_W-1:0]          rd_masked;
    logic [ROW_W-1:0]          onehot_j;
    logic                      j_last, k_last;
    logic                      out_free;
    rc_pkg::unit_req_t         unit_req;
    logic [ROW_W-1:0]          unit_out;

    // Size in use, clamped to one at the bottom and to the store depth at the top.
    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_cur = SIZE_W'(1);
        end
        else if (matrix_size_reg > SIZE_W'(DEPTH))
        begin
            n_cur = SIZE_W'(DEPTH);
        end
        else
        begin
            n_cur = matrix_size_reg;
        end
        mask_cur = rc_pkg::col_mask(n_cur);
    end

    // Handshake and loop conditions.
    assign in_stall  = (state_reg != rc_pkg::ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign rl_inc    = {1'b0, rows_loaded_reg} + (SIZE_W + 1)'(1);
    assign complete  = (rl_inc >= {1'b0, n_cur});
    assign rd_masked = rd_data_reg & mask_reg;
    assign onehot_j  = ROW_W'(1) << j_reg;
    assign j_last    = (j_reg == nlast_reg);
    assign k_last    = (k_reg == nlast_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    // Shared conditional-OR unit.
    rc_row_unit u_row_unit (
        .req    (unit_req),
        .result (unit_out)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg  <= rc_pkg::MATRIX_SIZE_RESET;
            closure_mode_reg <= rc_pkg::CLOSURE_MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rc_pkg::CFG_MATRIX_SIZE:  matrix_size_reg  <= cfg_data;
                rc_pkg::CFG_CLOSURE_MODE: closure_mode_reg <= cfg_data[rc_pkg::MODE_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc_pkg::ST_LOAD:
            begin
                if (in_accept && complete)
                begin
                    if (closure_mode_reg == rc_pkg::MODE_TRANSITIVE)
                    begin
                        state_next = rc_pkg::ST_PIV_RD;
                    end
                    else if (closure_mode_reg == rc_pkg::MODE_SYMMETRIC)
                    begin
                        state_next = rc_pkg::ST_SCOL_RD;
                    end
                    else
                    begin
                        state_next = rc_pkg::ST_EMIT_RD;
                    end
                end
            end
            rc_pkg::ST_PIV_RD:   state_next = rc_pkg::ST_PIV_CAP;
            rc_pkg::ST_PIV_CAP:  state_next = rc_pkg::ST_TROW_RD;
            rc_pkg::ST_TROW_RD:  state_next = rc_pkg::ST_TROW_UPD;
            rc_pkg::ST_TROW_UPD:
            begin
                if (!j_last)
                begin
                    state_next = rc_pkg::ST_TROW_RD;
                end
                else if (k_last)
                begin
                    state_next = rc_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = rc_pkg::ST_PIV_RD;
                end
            end
            rc_pkg::ST_SCOL_RD:  state_next = rc_pkg::ST_SCOL_ACC;
            rc_pkg::ST_SCOL_ACC:
            begin
                state_next = j_last ? rc_pkg::ST_SROW_RD : rc_pkg::ST_SCOL_RD;
            end
            rc_pkg::ST_SROW_RD:  state_next = rc_pkg::ST_SROW_UPD;
            rc_pkg::ST_SROW_UPD:
            begin
                state_next = k_last ? rc_pkg::ST_EMIT_RD : rc_pkg::ST_SCOL_RD;
            end
            rc_pkg::ST_EMIT_RD:  state_next = rc_pkg::ST_EMIT_OUT;
            rc_pkg::ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = j_last ? rc_pkg::ST_LOAD : rc_pkg::ST_EMIT_RD;
                end
            end
            default:             state_next = rc_pkg::ST_LOAD;
        endcase
    end

    // Datapath controls: counters, store access, row unit requests and output loads.
    always_comb
    begin
        rows_loaded_next = rows_loaded_reg;
        k_next           = k_reg;
        j_next           = j_reg;
        nlast_next       = nlast_reg;
        mask_next        = mask_reg;
        mode_next        = mode_reg;
        pivot_next       = pivot_reg;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && out_stall;
        closed_row_next  = closed_row_reg;
        row_index_next   = row_index_reg;
        last_row_next    = last_row_reg;
        mem_we           = 1'b0;
        mem_wa           = j_reg;
        mem_wd           = unit_out;
        mem_re           = 1'b0;
        mem_ra           = j_reg;

        unit_req            = '0;
        unit_req.base       = rd_masked;
        unit_req.test_word  = rd_masked;
        unit_req.test_sel   = rc_pkg::IDX_W'(k_reg);

        case (state_reg)
            rc_pkg::ST_LOAD:
            begin
                if (in_accept)
                begin
                    // Store the masked row, then either count it or start closing.
                    mem_we = (rows_loaded_reg < SIZE_W'(DEPTH));
                    mem_wa = rows_loaded_reg[ADDR_W-1:0];
                    mem_wd = row_bits & mask_cur;
                    if (complete)
                    begin
                        rows_loaded_next = '0;
                        nlast_next       = ADDR_W'(n_cur - SIZE_W'(1));
                        mask_next        = mask_cur;
                        mode_next        = closure_mode_reg;
                        k_next           = '0;
                        j_next           = '0;
                        acc_next         = '0;
                    end
                    else
                    begin
                        rows_loaded_next = rl_inc[SIZE_W-1:0];
                    end
                end
            end
            rc_pkg::ST_PIV_RD:
            begin
                mem_re = 1'b1;
                mem_ra = k_reg;
            end
            rc_pkg::ST_PIV_CAP:
            begin
                pivot_next = rd_masked;
                j_next     = '0;
            end
            rc_pkg::ST_TROW_RD:
            begin
                mem_re = 1'b1;
                mem_ra = j_reg;
            end
            rc_pkg::ST_TROW_UPD:
            begin
                // Row j picks up the pivot row when it reaches the pivot column.
                unit_req.operand = pivot_reg;
                mem_we = 1'b1;
                mem_wa = j_reg;
                if (j_last)
                begin
                    j_next = '0;
                    k_next = k_last ? '0 : k_reg + ADDR_W'(1);
                end
                else
                begin
                    j_next = j_reg + ADDR_W'(1);
                end
            end
            rc_pkg::ST_SCOL_RD:
            begin
                mem_re = 1'b1;
                mem_ra = j_reg;
            end
            rc_pkg::ST_SCOL_ACC:
            begin
                // Gather column k into the accumulator, one row per step.
                unit_req.base    = acc_reg;
                unit_req.operand = onehot_j;
                acc_next = unit_out;
                j_next   = j_last ? '0 : j_reg + ADDR_W'(1);
            end
            rc_pkg::ST_SROW_RD:
            begin
                mem_re = 1'b1;
                mem_ra = k_reg;
            end
            rc_pkg::ST_SROW_UPD:
            begin
                unit_req.operand    = acc_reg;
                unit_req.force_test = 1'b1;
                mem_we   = 1'b1;
                mem_wa   = k_reg;
                acc_next = '0;
                j_next   = '0;
                k_next   = k_last ? '0 : k_reg + ADDR_W'(1);
            end
            rc_pkg::ST_EMIT_RD:
            begin
                mem_re = 1'b1;
                mem_ra = j_reg;
            end
            rc_pkg::ST_EMIT_OUT:
            begin
                // Reflexive closure sets the diagonal bit on the way out.
                unit_req.operand    = onehot_j;
                unit_req.force_test = (mode_reg == rc_pkg::MODE_REFLEXIVE);
                unit_req.test_word  = '0;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    closed_row_next = unit_out;
                    row_index_next  = rc_pkg::IDX_W'(j_reg);
                    last_row_next   = j_last;
                    j_next          = j_last ? '0 : j_reg + ADDR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rc_pkg::ST_LOAD;
            rows_loaded_reg <= '0;
            k_reg           <= '0;
            j_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_loaded_reg <= rows_loaded_next;
            k_reg           <= k_next;
            j_reg           <= j_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        nlast_reg      <= nlast_next;
        mask_reg       <= mask_next;
        mode_reg       <= mode_next;
        pivot_reg      <= pivot_next;
        acc_reg        <= acc_next;
        closed_row_reg <= closed_row_next;
        row_index_reg  <= row_index_next;
        last_row_reg   <= last_row_next;
    end

    // Row store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= row_mem[mem_ra];
        end
    end

    // Output ports.
    assign out_valid  = out_valid_reg;
    assign closed_row = closed_row_reg;
    assign row_index  = row_index_reg;
    assign last_row   = last_row_reg;

endmodule

`default_nettype wire

/* sv/rc_checker.sv */
// Port-level assertions of the relation closure block and their bind to the top level.
`default_nettype none

module rc_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            cfg_we,
    input wire [rc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire [rc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [rc_pkg::ROW_W-1:0]        closed_row,
    input wire [rc_pkg::IDX_W-1:0]        row_index,
    input wire                            last_row
);

    logic [rc_pkg::IDX_W-1:0]  exp_idx_reg;
    logic [rc_pkg::MODE_W-1:0] mode_shadow_reg;

    // Expected index of the next row and a shadow of the closure mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg     <= '0;
            mode_shadow_reg <= rc_pkg::CLOSURE_MODE_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                exp_idx_reg <= last_row ? '0 : row_index + rc_pkg::IDX_W'(1);
            end
            if (cfg_we && (cfg_index == rc_pkg::CFG_CLOSURE_MODE))
            begin
                mode_shadow_reg <= cfg_data[rc_pkg::MODE_W-1:0];
            end
        end
    end

    // A stalled output transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(closed_row)
            && $stable(row_index) && $stable(last_row))
        else $error("output payload changed while stalled");

    // Rows of a matrix come out in index order starting at zero.
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index == exp_idx_reg)
        else $error("row index out of sequence");

    // Input stays stalled while a matrix is still being emitted.
    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |-> in_stall)
        else $error("input accepted in the middle of an emitted matrix");

    // The reflexive closure always carries its diagonal bit.
    a_reflexive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_shadow_reg == rc_pkg::MODE_REFLEXIVE) |-> closed_row[row_index])
        else $error("reflexive closure row lacks its diagonal bit");

endmodule

bind relation_closure_core rc_checker u_rc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .closed_row (closed_row),
    .row_index  (row_index),
    .last_row   (last_row)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the relation closure core, with its own closure predictor.
module tb_top;
    import rc_pkg::*;

    localparam int N_LIMIT = (MAX_SIZE_DEFAULT < 32) ? MAX_SIZE_DEFAULT : 32;
    localparam logic [MODE_W-1:0] MODE_UNCHANGED = 2'd3;
    localparam int RANDOM_ROWS   = 360;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;

    // One emitted row of the closed relation.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } closed_row_t;

    typedef enum logic {STEP_CFG, STEP_ROW} step_kind_t;

    // One line of the directed stimulus table.
    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ROW_W-1:0]      bits;
        bit                    typed;
        logic [ROW_W-1:0]      typed_row;
    } step_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [ROW_W-1:0]      row_bits  = '0;
    logic                  out_stall = 1'b0;
    wire                   in_stall;
    wire                   out_valid;
    wire  [ROW_W-1:0]      closed_row;
    wire  [IDX_W-1:0]      row_index;
    wire                   last_row;

    // Predictor state: a copy of the row store, load count and registers.
    logic [ROW_W-1:0]  mdl_store [N_LIMIT];
    logic [SIZE_W-1:0] mdl_loaded;
    logic [SIZE_W-1:0] mdl_size;
    logic [MODE_W-1:0] mdl_mode;

    closed_row_t rows_due [$];
    step_t       directed_steps [$];
    int          mismatches  = 0;
    int          rows_sent   = 0;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;

    relation_closure_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_bits   (row_bits),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .closed_row (closed_row),
        .row_index  (row_index),
        .last_row   (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Effective size: zero acts as one, large values saturate.
    function automatic int size_in_force();
        int n;
        n = mdl_size;
        if (n == 0)
            n = 1;
        if (n > N_LIMIT)
            n = N_LIMIT;
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] columns(input int n);
        if (n >= 32)
            return '1;
        return (32'h1 << n) - 32'h1;
    endfunction

    // Stores one accepted row and, when the matrix completes, queues its closed rows.
    task automatic accept_relation_row(input logic [ROW_W-1:0] bits, input bit typed,
                                       input logic [ROW_W-1:0] typed_row);
        int n;
        logic [ROW_W-1:0] m [32];
        logic [ROW_W-1:0] t [32];
        closed_row_t r;
        n = size_in_force();
        if (mdl_loaded < N_LIMIT)
            mdl_store[mdl_loaded] = bits & columns(n);
        mdl_loaded = mdl_loaded + 1'b1;
        if (int'(mdl_loaded) < n)
            return;
        for (int i = 0; i < n; i++)
            m[i] = mdl_store[i] & columns(n);
        case (mdl_mode)
            MODE_REFLEXIVE:
            begin
                for (int i = 0; i < n; i++)
                    m[i][i] = 1'b1;
            end
            MODE_SYMMETRIC:
            begin
                for (int i = 0; i < n; i++)
                begin
                    t[i] = '0;
                    for (int k = 0; k < n; k++)
                        if (m[k][i])
                            t[i][k] = 1'b1;
                end
                for (int i = 0; i < n; i++)
                    m[i] |= t[i];
            end
            MODE_TRANSITIVE:
            begin
                for (int k = 0; k < n; k++)
                    for (int i = 0; i < n; i++)
                        if (m[i][k])
                            m[i] |= m[k];
            end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            r.row  = (typed && n == 1) ? typed_row : m[i];
            r.idx  = IDX_W'(i);
            r.last = (i == n - 1);
            rows_due.push_back(r);
        end
        mdl_loaded = '0;
    endtask

    // Offers one row until it is taken, then idles between bursts.
    task automatic send_row(input logic [ROW_W-1:0] bits, input bit typed,
                            input logic [ROW_W-1:0] typed_row);
        in_valid <= 1'b1;
        row_bits <= bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accept_relation_row(bits, typed, typed_row);
        rows_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 10);
        end
    endtask

    // Stops offering rows until every queued result has come and the block is quiet.
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_MATRIX_SIZE)
            mdl_size = val[SIZE_W-1:0];
        else
            mdl_mode = val[MODE_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        step_t s;
        s = '{STEP_CFG, idx, val, '0, 1'b0, '0};
        directed_steps.push_back(s);
    endtask

    task automatic add_row(input logic [ROW_W-1:0] bits, input bit typed,
                           input logic [ROW_W-1:0] typed_row);
        step_t s;
        s = '{STEP_ROW, CFG_MATRIX_SIZE, '0, bits, typed, typed_row};
        directed_steps.push_back(s);
    endtask

    // Row contents: empty, full, dense, thinner and one or two set columns within the size.
    function automatic logic [ROW_W-1:0] random_row(input int n);
        logic [ROW_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2, 3, 4: v = $urandom();
            5, 6: v = $urandom() & $urandom();
            default:
            begin
                v = '0;
                v[$urandom_range(0, n - 1)] = 1'b1;
                if ($urandom_range(0, 1) == 1)
                    v[$urandom_range(0, n - 1)] = 1'b1;
            end
        endcase
        return v;
    endfunction

    // Compare each accepted result against the oldest queued row.
    always @(posedge clk)
    begin : check_results
        closed_row_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
            begin
                $error("unexpected transaction: closed_row %h row_index %0d last_row %0d",
                       closed_row, row_index, last_row);
                mismatches++;
            end
            else
            begin
                due = rows_due.pop_front();
                if (closed_row !== due.row)
                begin
                    $error("closed_row: expected %h, actual %h", due.row, closed_row);
                    mismatches++;
                end
                if (row_index !== due.idx)
                begin
                    $error("row_index: expected %0d, actual %0d", due.idx, row_index);
                    mismatches++;
                end
                if (last_row !== due.last)
                begin
                    $error("last_row: expected %0d, actual %0d", due.last, last_row);
                    mismatches++;
                end
            end
        end
    end

    // Output back-pressure in stretches of varying style, plus one long hold-off.
    initial
    begin
        int stretch;
        int style;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                for (int c = 0; c < HOLD_CYCLES; c++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end
            stretch = $urandom_range(8, 60);
            style   = $urandom_range(0, 3);
            repeat (stretch)
            begin
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ~out_stall;
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus: directed table first, then random matrices.
    initial
    begin
        int n;
        int k;
        int goal;
        int pick;
        int size_val;
        int matrices;
        step_t s;
        mdl_size   = MATRIX_SIZE_RESET;
        mdl_mode   = CLOSURE_MODE_RESET;
        mdl_loaded = '0;
        for (int i = 0; i < N_LIMIT; i++)
            mdl_store[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rows under the reset size give no result; lowering the size mid-load completes.
        add_row(32'h0000_0002, 1'b0, '0);
        add_row(32'h8000_0001, 1'b0, '0);
        add_row(32'hFFFF_FFFF, 1'b0, '0);
        add_cfg(CFG_MATRIX_SIZE, 6'd2);
        add_row(32'h0000_0000, 1'b0, '0);
        // A size of zero acts as one; columns beyond the size are dropped.
        add_cfg(CFG_MATRIX_SIZE, 6'd0);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_REFLEXIVE));
        add_row(32'h0000_0000, 1'b1, 32'h0000_0001);
        add_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_UNCHANGED));
        add_row(32'h0000_0000, 1'b1, 32'h0000_0000);
        add_row(32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_SYMMETRIC));
        add_row(32'hFFFF_FFFE, 1'b1, 32'h0000_0000);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_TRANSITIVE));
        add_row(32'h0000_0001, 1'b1, 32'h0000_0001);
        // Small symmetric and transitive matrices.
        add_cfg(CFG_MATRIX_SIZE, 6'd3);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_SYMMETRIC));
        add_row(32'h0000_0002, 1'b0, '0);
        add_row(32'h0000_0004, 1'b0, '0);
        add_row(32'h0000_0000, 1'b0, '0);
        add_cfg(CFG_MATRIX_SIZE, 6'd4);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_TRANSITIVE));
        add_row(32'h0000_0002, 1'b0, '0);
        add_row(32'h0000_0004, 1'b0, '0);
        add_row(32'h0000_0008, 1'b0, '0);
        add_row(32'h0000_0001, 1'b0, '0);
        // The mode is taken on the completing row.
        add_cfg(CFG_MATRIX_SIZE, 6'd3);
        add_row(32'h0000_0002, 1'b0, '0);
        add_row(32'h0000_0004, 1'b0, '0);
        add_cfg(CFG_CLOSURE_MODE, CFG_DATA_W'(MODE_REFLEXIVE));
        add_row(32'h0000_0000, 1'b0, '0);

        foreach (directed_steps[i])
        begin
            s = directed_steps[i];
            if (s.kind == STEP_CFG)
                write_reg(s.reg_idx, s.reg_val);
            else
                send_row(s.bits, s.typed, s.typed_row);
        end

        // Random matrices, mostly small; the first one uses an oversized setting.
        // No register is written while the long output hold is pending, so rows keep
        // coming and the block fills up.
        goal = rows_sent + RANDOM_ROWS;
        matrices = 0;
        while (rows_sent < goal)
        begin
            if ((matrices == 0 || $urandom_range(0, 1) == 0) && !hold_req)
            begin
                pick = $urandom_range(0, 19);
                if (matrices == 0)
                    size_val = $urandom_range(33, 63);
                else if (pick < 13)
                    size_val = $urandom_range(1, 6);
                else if (pick < 16)
                    size_val = $urandom_range(7, 12);
                else if (pick == 16)
                    size_val = 32;
                else if (pick == 17)
                    size_val = $urandom_range(33, 63);
                else if (pick == 18)
                    size_val = 0;
                else
                    size_val = $urandom_range(13, 31);
                write_reg(CFG_MATRIX_SIZE, CFG_DATA_W'(size_val));
                write_reg(CFG_CLOSURE_MODE, {4'($urandom()), MODE_W'($urandom_range(0, 3))});
            end
            if (matrices == 3)
                hold_req = 1'b1;
            n = size_in_force();
            if (n > 1 && !hold_req && $urandom_range(0, 9) == 0)
            begin
                // Partial load, then a smaller size so the next row completes.
                k = $urandom_range(1, n - 1);
                repeat (k) send_row(random_row(n), 1'b0, '0);
                write_reg(CFG_MATRIX_SIZE, CFG_DATA_W'($urandom_range(0, k + 1)));
                send_row(random_row(size_in_force()), 1'b0, '0);
            end
            else
            begin
                repeat (n) send_row(random_row(n), 1'b0, '0);
            end
            matrices++;
        end

        drain_and_settle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

/* sim.f */
sv/rc_pkg.sv
sv/rc_row_unit.sv
sv/relation_closure_core.sv
sv/rc_checker.sv
sim/tb_top.sv
